>>> rtl/pfr_pkg.sv
package pfr_pkg;

    localparam int FRAME_IDX_W = 5;
    localparam int PAGE_W      = 16;
    localparam int PROC_W      = 8;
    localparam int TIME_W      = 32;
    localparam int FIU_W       = 6;
    localparam int CFG_IDX_W   = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 1'b1;

    // Replacement policy codes.
    localparam logic POL_FIFO = 1'b0;
    localparam logic POL_LRU  = 1'b1;

    localparam logic [FIU_W-1:0] FIU_RESET = 6'd32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_WRITE
    } t_state;

    // Table command: read strobe and write enables.
    typedef struct packed {
        logic rd_en;
        logic key_we;
        logic last_we;
        logic set_valid;
    } t_tbl_cmd;

    typedef struct packed {
        logic [FRAME_IDX_W-1:0] frame_index;
        logic                   page_fault;
        logic                   evicted_valid;
        logic [PAGE_W-1:0]      evicted_page;
        logic [PROC_W-1:0]      evicted_process;
        logic [TIME_W-1:0]      evicted_residency;
    } t_result;

endpackage

>>> rtl/page_frame_replacement_top.sv
// Page frame table with FIFO or LRU replacement.
//
// Input channel: i_in_valid / o_in_stall carry one reference (page, process,
// time). A transfer happens at a rising edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall carry one result per reference:
// the frame now holding the page, the fault flag and any eviction details.
//
// Each reference scans the active frames one per cycle through the single
// read port of the frame table, highest index first, while one compare unit
// looks for a hit, a free frame and the replacement victim at once. The result
// then goes from the write-back step into the output register, and a new
// reference is taken only once the previous one has left that step.
// o_in_stall is high while a reference is in work.
//
// The output register holds a finished result while the receiver stalls. The next
// reference is still taken and scanned; only its write-back waits for that register.
//
// Reset clears all frame valid bits at once (no clearing pass), selects FIFO
// and sets the frame count to 32. Configuration writes go through i_cfg_we,
// i_cfg_index and i_cfg_data. The user makes them only while the block is idle, unchecked by it.
module page_frame_replacement_top
    import pfr_pkg::*;
#(
    parameter int NUM_FRAMES = 32,
    parameter int PAGE_BITS  = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [FIU_W-1:0]       i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [PAGE_W-1:0]      i_page_number,
    input  logic [PROC_W-1:0]      i_process_ident,
    input  logic [TIME_W-1:0]      i_access_time,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [FRAME_IDX_W-1:0] o_frame_index,
    output logic                   o_page_fault,
    output logic                   o_evicted_valid,
    output logic [PAGE_W-1:0]      o_evicted_page,
    output logic [PROC_W-1:0]      o_evicted_process,
    output logic [TIME_W-1:0]      o_evicted_residency
);

    localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    // Stored page width: the page port is 16 bits, PAGE_BITS may narrow it.
    localparam int PW = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;

    logic              r_policy;
    logic [FIU_W-1:0]  r_frames;
    logic [IW-1:0]     last_idx;
    logic              in_xfer;
    logic              busy;
    t_tbl_cmd          tbl_cmd;
    logic [IW-1:0]     rd_addr;
    logic [IW-1:0]     wr_addr;
    logic [PW-1:0]     wr_page;
    logic [PROC_W-1:0] wr_owner;
    logic [TIME_W-1:0] wr_time;
    logic              rd_valid;
    logic [PW-1:0]     rd_page;
    logic [PROC_W-1:0] rd_owner;
    logic [TIME_W-1:0] rd_load;
    logic [TIME_W-1:0] rd_last;
    logic              res_valid;
    logic              res_ready;
    t_result           res;
    logic              r_out_valid;
    t_result           r_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_FIFO;
            r_frames <= FIU_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_POLICY_MODE:   r_policy <= i_cfg_data[0];
                CFG_FRAMES_IN_USE: r_frames <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Highest active frame index: a count of zero acts as one, and a count
    // above the table size is clipped to the table size.
    always_comb begin
        if (r_frames == '0) begin
            last_idx = '0;
        end else if (32'(r_frames) > 32'(NUM_FRAMES)) begin
            last_idx = IW'(NUM_FRAMES - 1);
        end else begin
            last_idx = IW'(r_frames - 1'b1);
        end
    end

    assign o_in_stall = busy;
    assign in_xfer    = i_in_valid && !busy;

    pfr_seq #(
        .IW (IW),
        .PW (PW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_xfer),
        .i_page      (i_page_number[PW-1:0]),
        .i_proc      (i_process_ident),
        .i_now       (i_access_time),
        .i_policy    (r_policy),
        .i_last_idx  (last_idx),
        .o_busy      (busy),
        .o_cmd       (tbl_cmd),
        .o_rd_addr   (rd_addr),
        .o_wr_addr   (wr_addr),
        .o_wr_page   (wr_page),
        .o_wr_owner  (wr_owner),
        .o_wr_time   (wr_time),
        .i_rd_valid  (rd_valid),
        .i_rd_page   (rd_page),
        .i_rd_owner  (rd_owner),
        .i_rd_load   (rd_load),
        .i_rd_last   (rd_last),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    pfr_table #(
        .NUM_FRAMES (NUM_FRAMES),
        .IW         (IW),
        .PW         (PW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (tbl_cmd),
        .i_rd_addr  (rd_addr),
        .i_wr_addr  (wr_addr),
        .i_wr_page  (wr_page),
        .i_wr_owner (wr_owner),
        .i_wr_time  (wr_time),
        .o_rd_valid (rd_valid),
        .o_rd_page  (rd_page),
        .o_rd_owner (rd_owner),
        .o_rd_load  (rd_load),
        .o_rd_last  (rd_last)
    );

    // Output register: loads when empty or when its result is transferred
    // in the same cycle.
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_frame_index       = r_out.frame_index;
    assign o_page_fault        = r_out.page_fault;
    assign o_evicted_valid     = r_out.evicted_valid;
    assign o_evicted_page      = r_out.evicted_page;
    assign o_evicted_process   = r_out.evicted_process;
    assign o_evicted_residency = r_out.evicted_residency;

`ifndef NO_ASSERTIONS
    // A transfer starts a scan, so the input side must stall next cycle.
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("input not stalled after a transfer");

    // A hit never reports an eviction.
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_page_fault) |-> !o_evicted_valid)
        else $error("eviction reported on a hit");

    // A result is only handed over from the write-back step while busy.
    a_res_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> busy)
        else $error("result produced while idle");
`endif

endmodule

>>> rtl/pfr_table.sv
module pfr_table
    import pfr_pkg::*;
#(
    parameter int NUM_FRAMES = 32,
    parameter int IW         = 5,
    parameter int PW         = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_tbl_cmd          i_cmd,
    input  logic [IW-1:0]     i_rd_addr,
    input  logic [IW-1:0]     i_wr_addr,
    input  logic [PW-1:0]     i_wr_page,
    input  logic [PROC_W-1:0] i_wr_owner,
    input  logic [TIME_W-1:0] i_wr_time,
    output logic              o_rd_valid,
    output logic [PW-1:0]     o_rd_page,
    output logic [PROC_W-1:0] o_rd_owner,
    output logic [TIME_W-1:0] o_rd_load,
    output logic [TIME_W-1:0] o_rd_last
);

    logic [NUM_FRAMES-1:0] r_valid;
    logic [PW-1:0]         r_mem_page  [NUM_FRAMES];
    logic [PROC_W-1:0]     r_mem_owner [NUM_FRAMES];
    logic [TIME_W-1:0]     r_mem_load  [NUM_FRAMES];
    logic [TIME_W-1:0]     r_mem_last  [NUM_FRAMES];
    logic                  r_rd_valid;
    logic [PW-1:0]         r_rd_page;
    logic [PROC_W-1:0]     r_rd_owner;
    logic [TIME_W-1:0]     r_rd_load;
    logic [TIME_W-1:0]     r_rd_last;

    // Valid bits are the only per-frame state cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.set_valid) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_we) begin
            r_mem_page[i_wr_addr]  <= i_wr_page;
            r_mem_owner[i_wr_addr] <= i_wr_owner;
            r_mem_load[i_wr_addr]  <= i_wr_time;
        end
        if (i_cmd.last_we) begin
            r_mem_last[i_wr_addr] <= i_wr_time;
        end
        if (i_cmd.rd_en) begin
            r_rd_valid <= r_valid[i_rd_addr];
            r_rd_page  <= r_mem_page[i_rd_addr];
            r_rd_owner <= r_mem_owner[i_rd_addr];
            r_rd_load  <= r_mem_load[i_rd_addr];
            r_rd_last  <= r_mem_last[i_rd_addr];
        end
    end

    assign o_rd_valid = r_rd_valid;
    assign o_rd_page  = r_rd_page;
    assign o_rd_owner = r_rd_owner;
    assign o_rd_load  = r_rd_load;
    assign o_rd_last  = r_rd_last;

endmodule

>>> rtl/pfr_seq.sv
module pfr_seq
    import pfr_pkg::*;
#(
    parameter int IW = 5,
    parameter int PW = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PW-1:0]     i_page,
    input  logic [PROC_W-1:0] i_proc,
    input  logic [TIME_W-1:0] i_now,
    input  logic              i_policy,
    input  logic [IW-1:0]     i_last_idx,
    output logic              o_busy,
    output t_tbl_cmd          o_cmd,
    output logic [IW-1:0]     o_rd_addr,
    output logic [IW-1:0]     o_wr_addr,
    output logic [PW-1:0]     o_wr_page,
    output logic [PROC_W-1:0] o_wr_owner,
    output logic [TIME_W-1:0] o_wr_time,
    input  logic              i_rd_valid,
    input  logic [PW-1:0]     i_rd_page,
    input  logic [PROC_W-1:0] i_rd_owner,
    input  logic [TIME_W-1:0] i_rd_load,
    input  logic [TIME_W-1:0] i_rd_last,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_result           o_res
);

    t_state            r_state, n_state;
    logic              r_rd_vld, n_rd_vld;
    logic [IW-1:0]     r_addr, n_addr;
    logic [IW-1:0]     r_rd_idx, n_rd_idx;
    logic [PW-1:0]     r_page, n_page;
    logic [PROC_W-1:0] r_proc, n_proc;
    logic [TIME_W-1:0] r_now, n_now;
    logic              r_hit, n_hit;
    logic [IW-1:0]     r_hit_idx, n_hit_idx;
    logic              r_free, n_free;
    logic [IW-1:0]     r_free_idx, n_free_idx;
    logic              r_first, n_first;
    logic [TIME_W-1:0] r_best, n_best;
    logic [IW-1:0]     r_best_idx, n_best_idx;
    logic [PW-1:0]     r_vic_page, n_vic_page;
    logic [PROC_W-1:0] r_vic_proc, n_vic_proc;
    logic [TIME_W-1:0] r_vic_load, n_vic_load;
    logic [TIME_W-1:0] cand_time;

    assign cand_time = (i_policy == POL_LRU) ? i_rd_last : i_rd_load;

    always_comb begin
        n_state    = r_state;
        n_rd_vld   = 1'b0;
        n_addr     = r_addr;
        n_rd_idx   = r_rd_idx;
        n_page     = r_page;
        n_proc     = r_proc;
        n_now      = r_now;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        n_first    = r_first;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_vic_page = r_vic_page;
        n_vic_proc = r_vic_proc;
        n_vic_load = r_vic_load;
        o_cmd      = '0;
        o_wr_addr  = r_hit_idx;
        o_wr_page  = r_page;
        o_wr_owner = r_proc;
        o_wr_time  = r_now;
        o_res      = '0;
        o_res_valid = 1'b0;

        // Compare unit: one frame's read data per cycle, highest index first.
        if (r_rd_vld) begin
            if (!r_hit && i_rd_valid && i_rd_page == r_page && i_rd_owner == r_proc) begin
                n_hit     = 1'b1;
                n_hit_idx = r_rd_idx;
            end
            if (!r_free && !i_rd_valid) begin
                n_free     = 1'b1;
                n_free_idx = r_rd_idx;
            end
            // Strictly smaller only, so ties keep the higher index seen earlier.
            if (r_first || cand_time < r_best) begin
                n_first    = 1'b0;
                n_best     = cand_time;
                n_best_idx = r_rd_idx;
                n_vic_page = i_rd_page;
                n_vic_proc = i_rd_owner;
                n_vic_load = i_rd_load;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_page  = i_page;
                    n_proc  = i_proc;
                    n_now   = i_now;
                    n_addr  = i_last_idx;
                    n_hit   = 1'b0;
                    n_free  = 1'b0;
                    n_first = 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.rd_en = 1'b1;
                n_rd_vld    = 1'b1;
                n_rd_idx    = r_addr;
                if (r_addr == '0) begin
                    n_state = ST_LAST;
                end else begin
                    n_addr = r_addr - 1'b1;
                end
            end
            ST_LAST: begin
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                o_res_valid = 1'b1;
                if (r_hit) begin
                    o_res.frame_index = FRAME_IDX_W'(r_hit_idx);
                    o_wr_addr         = r_hit_idx;
                    o_cmd.last_we     = i_res_ready && (i_policy == POL_LRU);
                end else if (r_free) begin
                    o_res.frame_index = FRAME_IDX_W'(r_free_idx);
                    o_res.page_fault  = 1'b1;
                    o_wr_addr         = r_free_idx;
                    o_cmd.key_we      = i_res_ready;
                    o_cmd.last_we     = i_res_ready;
                    o_cmd.set_valid   = i_res_ready;
                end else begin
                    o_res.frame_index       = FRAME_IDX_W'(r_best_idx);
                    o_res.page_fault        = 1'b1;
                    o_res.evicted_valid     = 1'b1;
                    o_res.evicted_page      = PAGE_W'(r_vic_page);
                    o_res.evicted_process   = r_vic_proc;
                    o_res.evicted_residency = r_now - r_vic_load;
                    o_wr_addr               = r_best_idx;
                    o_cmd.key_we            = i_res_ready;
                    o_cmd.last_we           = i_res_ready;
                    o_cmd.set_valid         = i_res_ready;
                end
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_rd_idx   <= n_rd_idx;
        r_page     <= n_page;
        r_proc     <= n_proc;
        r_now      <= n_now;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_free     <= n_free;
        r_free_idx <= n_free_idx;
        r_first    <= n_first;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_vic_page <= n_vic_page;
        r_vic_proc <= n_vic_proc;
        r_vic_load <= n_vic_load;
    end

    assign o_busy    = (r_state != ST_IDLE);
    assign o_rd_addr = r_addr;

endmodule

>>> sim/testbench.sv
module testbench;
    import pfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The frame table is instantiated at its full size of 32 frames.
    localparam int TABLE_DEPTH = 32;
    // Cycles without any transfer on either channel before the run is abandoned.
    // The time a correct reference spends in the block, with random sender gaps and
    // receiver stalls added, stays far below this limit, so the margin is generous.
    localparam int WATCHDOG_LIMIT = 20000;
    // Cycles to wait after the last result before the verdict.
    localparam int TAIL_CYCLES = 40;

    // Software copy of the frame table. Every accepted reference is replayed here
    // in acceptance order. Each result that the block returns is compared with the
    // oldest outcome still waiting in the queue.
    class t_frame_table_tracker;
        bit                     used [TABLE_DEPTH];
        logic [PAGE_W-1:0]      page [TABLE_DEPTH];
        logic [PROC_W-1:0]      owner [TABLE_DEPTH];
        logic [TIME_W-1:0]      load_t [TABLE_DEPTH];
        logic [TIME_W-1:0]      last_t [TABLE_DEPTH];
        logic                   policy;
        logic [FIU_W-1:0]       frame_count;
        t_result                outcome_q [$];
        int                     error_count;

        function new();
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                used[k]   = 1'b0;
                page[k]   = '0;
                owner[k]  = '0;
                load_t[k] = '0;
                last_t[k] = '0;
            end
            policy      = POL_FIFO;
            frame_count = FIU_RESET;
            error_count = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [FIU_W-1:0] data);
            if (idx == CFG_POLICY_MODE) begin
                policy = data[0];
            end else begin
                frame_count = data;
            end
        endfunction

        // A count of zero behaves as one frame and a count above the table
        // depth behaves as the whole table.
        function int active_frames();
            if (frame_count == 0) return 1;
            if (frame_count > TABLE_DEPTH) return TABLE_DEPTH;
            return int'(frame_count);
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        function void note_reference(logic [PAGE_W-1:0] pg, logic [PROC_W-1:0] pid,
                                     logic [TIME_W-1:0] now);
            t_result         r;
            int              n;
            int              slot;
            bit              hit;
            logic [TIME_W-1:0] best;
            logic [TIME_W-1:0] age;

            r    = '0;
            n    = active_frames();
            hit  = 1'b0;
            slot = -1;

            // The search runs from the top down, so the highest matching frame wins.
            for (int k = n - 1; k >= 0 && !hit; k--) begin
                if (used[k] && page[k] == pg && owner[k] == pid) begin
                    if (policy == POL_LRU) last_t[k] = now;
                    r.frame_index = FRAME_IDX_W'(k);
                    hit = 1'b1;
                end
            end

            if (!hit) begin
                r.page_fault = 1'b1;
                for (int k = n - 1; k >= 0 && slot < 0; k--) begin
                    if (!used[k]) slot = k;
                end
                if (slot < 0) begin
                    // A strict less-than keeps the higher index when stamps are equal.
                    slot = n - 1;
                    best = (policy == POL_LRU) ? last_t[slot] : load_t[slot];
                    for (int k = n - 2; k >= 0; k--) begin
                        age = (policy == POL_LRU) ? last_t[k] : load_t[k];
                        if (age < best) begin
                            best = age;
                            slot = k;
                        end
                    end
                    r.evicted_valid     = 1'b1;
                    r.evicted_page      = page[slot];
                    r.evicted_process   = owner[slot];
                    r.evicted_residency = now - load_t[slot];
                end
                used[slot]    = 1'b1;
                page[slot]    = pg;
                owner[slot]   = pid;
                load_t[slot]  = now;
                last_t[slot]  = now;
                r.frame_index = FRAME_IDX_W'(slot);
            end
            outcome_q.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result exp;
            string   bad;

            if (outcome_q.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("[%0t] result without a pending reference: frame %0d fault %0b",
                             $realtime, got.frame_index, got.page_fault);
                end
                return;
            end
            exp = outcome_q.pop_front();
            bad = "";
            if (got.frame_index !== exp.frame_index) bad = {bad, " frame_index"};
            if (got.page_fault !== exp.page_fault) bad = {bad, " page_fault"};
            if (got.evicted_valid !== exp.evicted_valid) bad = {bad, " evicted_valid"};
            if (got.evicted_page !== exp.evicted_page) bad = {bad, " evicted_page"};
            if (got.evicted_process !== exp.evicted_process) bad = {bad, " evicted_process"};
            if (got.evicted_residency !== exp.evicted_residency) begin
                bad = {bad, " evicted_residency"};
            end
            if (bad != "") begin
                error_count++;
                if (error_count <= 10) begin
                    $display("[%0t] mismatch in%s", $realtime, bad);
                    $display("    expected: frame %0d fault %0b ev %0b page %h proc %h res %h",
                             exp.frame_index, exp.page_fault, exp.evicted_valid,
                             exp.evicted_page, exp.evicted_process, exp.evicted_residency);
                    $display("    actual:   frame %0d fault %0b ev %0b page %h proc %h res %h",
                             got.frame_index, got.page_fault, got.evicted_valid,
                             got.evicted_page, got.evicted_process, got.evicted_residency);
                end
            end
        endfunction
    endclass

    // A page and process pair that the random references keep coming back to.
    typedef struct {
        logic [PAGE_W-1:0] page;
        logic [PROC_W-1:0] proc;
    } t_ref_key;

    // Every input has a known value from time zero.
    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [FIU_W-1:0]       i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic [PAGE_W-1:0]      i_page_number = '0;
    logic [PROC_W-1:0]      i_process_ident = '0;
    logic [TIME_W-1:0]      i_access_time = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [FRAME_IDX_W-1:0] o_frame_index;
    logic                   o_page_fault;
    logic                   o_evicted_valid;
    logic [PAGE_W-1:0]      o_evicted_page;
    logic [PROC_W-1:0]      o_evicted_process;
    logic [TIME_W-1:0]      o_evicted_residency;

    t_frame_table_tracker   table_copy;
    int                     send_idle_pct = 0;
    int                     out_stall_pct = 0;
    int                     quiet_cycles = 0;
    logic [TIME_W-1:0]      now_stamp = '0;
    t_ref_key               hot_set [64];
    int                     hot_size = 1;

    page_frame_replacement_top #(
        .NUM_FRAMES (TABLE_DEPTH),
        .PAGE_BITS  (PAGE_W)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_page_number       (i_page_number),
        .i_process_ident     (i_process_ident),
        .i_access_time       (i_access_time),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_frame_index       (o_frame_index),
        .o_page_fault        (o_page_fault),
        .o_evicted_valid     (o_evicted_valid),
        .o_evicted_page      (o_evicted_page),
        .o_evicted_process   (o_evicted_process),
        .o_evicted_residency (o_evicted_residency)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // The receiver stalls at random, at the rate set for the current phase.
    // It does not depend on whether a result is actually waiting.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // Output monitor and watchdog. Values are read in the active region of the
    // edge, before any nonblocking update. They are therefore the values that the
    // block saw at that edge.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got.frame_index       = o_frame_index;
                got.page_fault        = o_page_fault;
                got.evicted_valid     = o_evicted_valid;
                got.evicted_page      = o_evicted_page;
                got.evicted_process   = o_evicted_process;
                got.evicted_residency = o_evicted_residency;
                table_copy.check_result(got);
            end
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] no transfer for %0d cycles", $realtime, quiet_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Offers one reference and returns at the edge where it is transferred. The
    // valid is lowered only when a random gap comes before this reference. When
    // no gap comes, valid stays high from the previous transfer with no dip.
    task automatic send_ref(logic [PAGE_W-1:0] pg, logic [PROC_W-1:0] pid,
                            logic [TIME_W-1:0] stamp);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_page_number   <= pg;
        i_process_ident <= pid;
        i_access_time   <= stamp;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        table_copy.note_reference(pg, pid, stamp);
    endtask

    // Stops offering input and waits until every expected result has been
    // transferred. Because each reference yields exactly one result, the block
    // is idle from then on.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (table_copy.pending() != 0) @(posedge i_clk);
    endtask

    // Writes both registers on back-to-back edges while the block is idle. The
    // write enable stays high across the two writes, so it changes only once
    // per time step.
    task automatic configure(logic pol, logic [FIU_W-1:0] count);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_POLICY_MODE;
        i_cfg_data  <= FIU_W'(pol);
        @(posedge i_clk);
        table_copy.write_reg(CFG_POLICY_MODE, FIU_W'(pol));
        i_cfg_index <= CFG_FRAMES_IN_USE;
        i_cfg_data  <= count;
        @(posedge i_clk);
        table_copy.write_reg(CFG_FRAMES_IN_USE, count);
        i_cfg_we <= 1'b0;
    endtask

    // Builds the set of pairs that most random references reuse. Its size lies
    // between the active frame count and twice that count (at most 64), so hits, free fills and evictions all
    // happen. Some entries repeat the page of the previous entry under another
    // process, which checks that matching takes the owner into account.
    task automatic build_hot_set(int frames);
        hot_size = frames + $urandom_range(frames);
        if (hot_size > 64) hot_size = 64;
        for (int k = 0; k < hot_size; k++) begin
            if (k > 0 && $urandom_range(3) == 0) begin
                hot_set[k].page = hot_set[k-1].page;
            end else begin
                hot_set[k].page = PAGE_W'($urandom_range(16'hFFFF));
            end
            hot_set[k].proc = PROC_W'($urandom_range(255));
        end
    endtask

    // Sends a random phase of references. Most of them reuse the hot set. Time
    // stamps usually advance by zero to three, so equal stamps test the
    // tie-breaking. Rare large jumps carry the stamp across the full 32-bit range,
    // and rare steps backward make the residency wrap around.
    task automatic random_phase(int count);
        int                sel;
        logic [PAGE_W-1:0] pg;
        logic [PROC_W-1:0] pid;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 75) begin
                sel = $urandom_range(hot_size - 1);
                pg  = hot_set[sel].page;
                pid = hot_set[sel].proc;
            end else if (sel < 80) begin
                pg  = hot_set[$urandom_range(hot_size - 1)].page;
                pid = PROC_W'($urandom_range(255));
            end else begin
                pg  = PAGE_W'($urandom_range(16'hFFFF));
                pid = PROC_W'($urandom_range(255));
            end
            sel = $urandom_range(99);
            if (sel < 3) begin
                now_stamp = now_stamp + $urandom;
            end else if (sel < 5) begin
                now_stamp = now_stamp - $urandom_range(50);
            end else begin
                now_stamp = now_stamp + $urandom_range(3);
            end
            send_ref(pg, pid, now_stamp);
        end
    endtask

    initial begin
        logic [FIU_W-1:0] phase_counts [12];
        int               eff;

        table_copy = new();
        phase_counts = '{6'd32, 6'd1, 6'd4, 6'd63, 6'd8, 6'd0,
                         6'd16, 6'd3, 6'd32, 6'd6, 6'd2, 6'd24};

        // Reset is asserted from time zero and released once.
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Both channels run without gaps here. The first write
        // restores the reset setting, so that every register is written.
        configure(POL_FIFO, 6'd32);
        send_ref(16'h0000, 8'h00, 32'h0000_0000);    // process zero, empty table
        send_ref(16'hFFFF, 8'hFF, 32'hFFFF_FFFF);    // all-ones fields
        send_ref(16'h0000, 8'h00, 32'h0000_0001);    // hit, time stepped backward
        send_ref(16'h0000, 8'h01, 32'h0000_0002);    // same page, other owner
        send_ref(16'hFFFF, 8'hFE, 32'h0000_0003);

        // With two frames, the upper frames keep their contents but drop out of
        // the search. Both fills carry the same stamp, so the first eviction must
        // take the higher frame. A stamp lower than the load time makes the
        // residency wrap.
        configure(POL_FIFO, 6'd2);
        send_ref(16'h0001, 8'h01, 32'd10);
        send_ref(16'h0002, 8'h01, 32'd10);
        send_ref(16'h0003, 8'h01, 32'd10);
        send_ref(16'h0004, 8'h01, 32'd5);
        send_ref(16'h0000, 8'h00, 32'd20);

        // With the full count again, the same page is resident in two frames.
        // The highest index must be taken as the hit.
        configure(POL_FIFO, 6'd32);
        send_ref(16'h0000, 8'h00, 32'd21);

        // In LRU mode, a hit refreshes the frame's stamp, which then saves the
        // frame from the next eviction.
        configure(POL_LRU, 6'd3);
        send_ref(16'h0007, 8'h07, 32'd30);
        send_ref(16'h0004, 8'h01, 32'd31);
        send_ref(16'h0007, 8'h07, 32'd40);
        send_ref(16'h0008, 8'h08, 32'd41);
        send_ref(16'h0009, 8'h09, 32'd42);

        // A count of zero must act as one frame.
        configure(POL_LRU, 6'd0);
        send_ref(16'h0009, 8'h09, 32'd50);
        send_ref(16'h000A, 8'h0A, 32'd51);

        // The largest count must act as the whole table.
        configure(POL_FIFO, 6'd63);
        send_ref(16'hAAAA, 8'h55, 32'd60);
        send_ref(16'h5555, 8'hAA, 32'd61);
        now_stamp = 32'd61;

        // Random phases. The four idle patterns rotate: no gaps, a mostly idle
        // sender, a mostly stalling receiver, and both at a moderate rate. The
        // frame count changes at every phase boundary, and the policy at most of them.
        for (int p = 0; p < 12; p++) begin
            configure(logic'((p % 2) ^ ((p / 4) % 2)), phase_counts[p]);
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    out_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 82;
                    out_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    out_stall_pct = 82;
                end
                default: begin
                    send_idle_pct = 26;
                    out_stall_pct = 26;
                end
            endcase
            eff = table_copy.active_frames();
            if (p == 0 || $urandom_range(1) == 1) build_hot_set(eff);
            random_phase(70);
        end

        drain();
        out_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (table_copy.error_count == 0 && table_copy.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
